[hw/rtl/fsps_pkg.sv]
// Package for the focus stack pixel select block.
// Holds payload structs, register indexes and controller/datapath command types.
package fsps_pkg;

    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_IMAGE_COUNT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_REFINE = 2'd2;

    typedef struct packed {
        logic [23:0] sharpness;
        logic [7:0]  pixel_red;
        logic [7:0]  pixel_green;
        logic [7:0]  pixel_blue;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  out_red;
        logic [7:0]  out_green;
        logic [7:0]  out_blue;
        logic [16:0] depth_value;
    } t_out_item;

    // Commands from controller to datapath.
    typedef struct packed {
        logic accumulate;  // take the accepted item into the running state
        logic finish;      // latch final decision for this pixel
        logic div_start;   // load the divider
        logic div_step;    // one restoring division step
        logic load_out;    // move result into the output register
    } t_dp_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic last_item;   // accepted item closes the pixel
        logic div_done;
    } t_dp_sts;

endpackage

[hw/rtl/focus_stack_pixel_select.sv]
// Focus stack pixel select, top level: configuration registers, controller, datapath.
// A pixel's result passes the finish stage, divider setup, the quotient-bit steps and the
// output load, and waits while the output register still holds an unread result.
// Throughput: one item per cycle within a pixel; after a pixel's last item the input is
// held off through divider setup, the quotient-bit steps and the output load.
// Reset (i_rst_n, synchronous, active low) clears control state and loads defaults.
module focus_stack_pixel_select
    import fsps_pkg::*;
#(
    parameter int MAX_IMAGES = 64,
    parameter int SCORE_BITS = 24
)(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  t_in_item                i_in_data,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output t_out_item               o_out_data,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [23:0]             i_cfg_data
);

    logic [23:0] r_threshold;
    logic [6:0]  r_image_count;
    logic        r_refine;
    t_dp_cmd     w_cmd;
    t_dp_sts     w_sts;

    assign o_cfg_ready = 1'b1;

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold   <= '0;
            r_image_count <= 7'd16;
            r_refine      <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_THRESHOLD:   r_threshold   <= i_cfg_data;
                REG_IMAGE_COUNT: r_image_count <= i_cfg_data[6:0];
                REG_REFINE:      r_refine      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    fsps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    fsps_datapath #(
        .MAX_IMAGES (MAX_IMAGES),
        .SCORE_BITS (SCORE_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item        (i_in_data),
        .i_threshold   (r_threshold),
        .i_image_count (r_image_count),
        .i_refine      (r_refine),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .o_result      (o_out_data)
    );

endmodule

[hw/rtl/fsps_ctrl.sv]
// Controller state machine for the focus stack pixel select block.
// Depends on fsps_pkg for the command and status structs.
module fsps_ctrl
    import fsps_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  logic    i_out_ready,
    output logic    o_out_valid,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        ST_ACCUM,
        ST_SETUP,
        ST_DIVIDE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_in_acc;

    // Input accepted only while accumulating.
    assign o_in_ready  = (r_state == ST_ACCUM);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state          = r_state;
        n_out_valid      = r_out_valid;
        o_cmd            = '0;
        o_cmd.accumulate = w_in_acc;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            ST_ACCUM: begin
                if (w_in_acc && i_sts.last_item) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_SETUP;
                end
            end
            ST_SETUP: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                // Result waits here until the output register is free.
                if (!i_sts.div_done) begin
                    o_cmd.div_step = 1'b1;
                end else if (!n_out_valid) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_ACCUM;
                end
            end
            default: n_state = ST_ACCUM;
        endcase
    end

    // State and registered output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_ACCUM;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

[hw/rtl/fsps_datapath.sv]
// Datapath for the focus stack pixel select block: running maximum,
// neighbor scores, depth fraction setup and a restoring divider.
// Depends on fsps_pkg for payload and command types.
module fsps_datapath
    import fsps_pkg::*;
#(
    parameter int MAX_IMAGES = 64,
    parameter int SCORE_BITS = 24
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_in_item    i_item,
    input  logic [23:0] i_threshold,
    input  logic [6:0]  i_image_count,
    input  logic        i_refine,
    input  t_dp_cmd     i_cmd,
    output t_dp_sts     o_sts,
    output t_out_item   o_result
);

    localparam int IDX_BITS = $clog2(MAX_IMAGES);
    localparam int N_BITS   = $clog2(MAX_IMAGES + 1);
    // Numerator/denominator width: 2*D*n with D up to ~4*2^SB.
    localparam int DW       = SCORE_BITS + N_BITS + 4;
    localparam int QBITS    = 17;
    localparam int RW       = DW + 1;

    logic [IDX_BITS-1:0]   r_cnt;
    logic [SCORE_BITS-1:0] r_best, r_prev, r_before, r_after;
    logic [IDX_BITS-1:0]   r_best_idx;
    logic [23:0]           r_best_col;

    logic [SCORE_BITS-1:0] w_score;
    logic [23:0]           w_color;
    logic [N_BITS-1:0]     w_n;
    logic                  w_first, w_take;

    // Clamp the configured image count to 1..MAX_IMAGES.
    always_comb begin
        if (i_image_count == 7'd0) begin
            w_n = N_BITS'(1);
        end else if (32'(i_image_count) > MAX_IMAGES) begin
            w_n = N_BITS'(MAX_IMAGES);
        end else begin
            w_n = N_BITS'(i_image_count);
        end
    end

    assign w_score          = SCORE_BITS'(i_item.sharpness);
    assign w_color          = {i_item.pixel_red, i_item.pixel_green, i_item.pixel_blue};
    assign w_first          = (r_cnt == '0);
    assign w_take           = w_first || (w_score > r_best);
    assign o_sts.last_item  = ((N_BITS+1)'(r_cnt) + 1'b1) >= (N_BITS+1)'(w_n);

    // Running maximum and neighbor tracking.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.accumulate) begin
            r_cnt <= o_sts.last_item ? '0 : r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accumulate) begin
            if (w_take) begin
                r_best     <= w_score;
                r_best_idx <= r_cnt;
                r_best_col <= w_color;
                r_before   <= w_first ? '0 : r_prev;
                r_after    <= '0;
            end else if ((IDX_BITS+1)'(r_cnt) == (IDX_BITS+1)'(r_best_idx) + 1'b1) begin
                r_after <= w_score;
            end
            r_prev <= w_score;
        end
    end

    // Finish stage: registers the selection and the refine inputs.
    logic                  r_sel_ok, r_fine;
    logic [23:0]           r_sel_col;
    logic [N_BITS-1:0]     r_n;
    logic [IDX_BITS-1:0]   r_idx;
    logic signed [SCORE_BITS+2:0] r_dd, r_diff;

    logic w_ok, w_fine_cond;
    logic signed [SCORE_BITS+2:0] w_sm, w_s0, w_sp, w_dd, w_diff;
    logic [SCORE_BITS-1:0] w_after;

    // Item that closes the pixel may itself be the after-neighbor.
    always_comb begin
        w_after = r_after;
        if (!w_take && ((IDX_BITS+1)'(r_cnt) == (IDX_BITS+1)'(r_best_idx) + 1'b1)) begin
            w_after = w_score;
        end
    end

    logic [SCORE_BITS-1:0] w_fbest, w_fbefore, w_fafter;
    logic [IDX_BITS-1:0]   w_fidx;
    logic [23:0]           w_fcol;
    assign w_fbest   = w_take ? w_score : r_best;
    assign w_fidx    = w_take ? r_cnt : r_best_idx;
    assign w_fcol    = w_take ? w_color : r_best_col;
    assign w_fbefore = w_take ? (w_first ? '0 : r_prev) : r_before;
    assign w_fafter  = w_take ? '0 : w_after;

    assign w_sm   = $signed((SCORE_BITS+3)'(w_fbefore));
    assign w_s0   = $signed((SCORE_BITS+3)'(w_fbest));
    assign w_sp   = $signed((SCORE_BITS+3)'(w_fafter));
    assign w_dd   = w_sm - (w_s0 <<< 1) + w_sp;
    assign w_diff = w_sm - w_sp;
    assign w_ok   = (32'(w_fbest) > 32'(i_threshold));
    assign w_fine_cond = i_refine && (w_fidx > IDX_BITS'(1))
                         && ((N_BITS+1)'(w_fidx) + 1'b1 < (N_BITS+1)'(w_n))
                         && (w_fbefore != '0) && (w_fafter != '0) && (w_dd != '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_sel_ok  <= w_ok;
            r_sel_col <= w_ok ? w_fcol : w_color;
            r_n       <= w_n;
            r_idx     <= w_fidx;
            r_fine    <= w_fine_cond;
            r_dd      <= w_dd;
            r_diff    <= w_diff;
        end
    end

    // Setup: numerator and denominator of the depth fraction.
    // Coarse: (n-idx)/n. Fine: (2D(n-idx) - diff) / (2Dn), sign normalized.
    logic signed [DW:0] w_nmi, w_num, w_den, w_dd2;
    logic signed [DW:0] w_num_p, w_den_p;
    assign w_nmi = $signed((DW+1)'(r_n)) - $signed((DW+1)'(r_idx));
    assign w_dd2 = (DW+1)'(r_dd) <<< 1;
    always_comb begin
        if (r_fine) begin
            w_num = w_dd2 * w_nmi - (DW+1)'(r_diff);
            w_den = w_dd2 * $signed((DW+1)'(r_n));
        end else begin
            w_num = w_nmi;
            w_den = $signed((DW+1)'(r_n));
        end
        if (w_den < 0) begin
            w_num_p = -w_num;
            w_den_p = -w_den;
        end else begin
            w_num_p = w_num;
            w_den_p = w_den;
        end
    end

    // Restoring divider: q = floor((num*2^17 + den) / (2*den)).
    logic [RW+QBITS:0] r_rem;
    logic [RW:0]       r_dvs;
    logic [QBITS:0]    r_q;
    logic [4:0]        r_step;
    logic              r_zero, r_full;
    localparam logic [4:0] STEPS = 5'(QBITS + 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else if (i_cmd.div_start) begin
            r_step <= STEPS;
        end else if (i_cmd.div_step && r_step != '0) begin
            r_step <= r_step - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_zero <= (w_num_p <= 0) || !r_sel_ok;
            r_full <= (w_num_p >= w_den_p);
            r_rem  <= ((RW+QBITS+1)'(w_num_p) << QBITS) + (RW+QBITS+1)'(w_den_p);
            r_dvs  <= (RW+1)'(w_den_p) << 1;
            r_q    <= '0;
        end else if (i_cmd.div_step && r_step != '0) begin
            // Shift amount is r_step-1 via the compare below.
            if (r_rem >= ((RW+QBITS+1)'(r_dvs) << (r_step - 1'b1))) begin
                r_rem <= r_rem - ((RW+QBITS+1)'(r_dvs) << (r_step - 1'b1));
                r_q   <= r_q | ((QBITS+1)'(1) << (r_step - 1'b1));
            end
        end
    end

    assign o_sts.div_done = (r_step == '0);

    logic [16:0] w_depth;
    always_comb begin
        if (r_zero) begin
            w_depth = '0;
        end else if (r_full || r_q > (QBITS+1)'(65536)) begin
            w_depth = 17'd65536;
        end else begin
            w_depth = r_q[16:0];
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_result.out_red     <= r_sel_col[23:16];
            o_result.out_green   <= r_sel_col[15:8];
            o_result.out_blue    <= r_sel_col[7:0];
            o_result.depth_value <= w_depth;
        end
    end

endmodule

[verif/focus_stack_pixel_select_checker.sv]
// Checker for the focus stack pixel select block: watches all channels,
// predicts each pixel result and compares. Depends on fsps_pkg.
`timescale 1ns / 100ps

module focus_stack_pixel_select_checker
    import fsps_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_data,
    input  logic      i_cfg_valid,
    input  logic      i_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [23:0] i_cfg_data,
    output int        o_fail_count,
    output int        o_pending
);
    localparam int MAX_N = 64;

    // Predictor copy of the configuration and per-pixel state.
    logic [23:0] thr;
    logic [6:0]  cnt_reg;
    logic        refine;
    int unsigned img_ctr, best_idx;
    logic [23:0] best_sc, prev_sc, sc_before, sc_after;
    logic [23:0] best_rgb;
    t_out_item   pixel_results[$];

    // Rounded Q1.16 ratio with clamp.
    function automatic logic [16:0] q16_depth(longint num, longint den);
        longint q;
        if (num <= 0 || den <= 0) return 17'd0;
        if (num >= den) return 17'd65536;
        q = (num * 131072 + den) / (2 * den);
        return (q > 65536) ? 17'd65536 : 17'(q);
    endfunction

    // Take one input transaction into the predicted state.
    task automatic take_item(t_in_item it);
        int unsigned n;
        longint nn, idx, sm, s0, sp, dd, num, den;
        t_out_item r;
        n = cnt_reg;
        if (n < 1) n = 1;
        if (n > MAX_N) n = MAX_N;
        if (img_ctr == 0 || it.sharpness > best_sc) begin
            best_sc = it.sharpness;
            best_idx = img_ctr;
            best_rgb = {it.pixel_red, it.pixel_green, it.pixel_blue};
            sc_before = (img_ctr == 0) ? 24'd0 : prev_sc;
            sc_after = 24'd0;
        end else if (img_ctr == best_idx + 1) begin
            sc_after = it.sharpness;
        end
        prev_sc = it.sharpness;
        if (img_ctr + 1 < n) begin
            img_ctr++;
            return;
        end
        if (best_sc > thr) begin
            nn = n;
            idx = best_idx;
            {r.out_red, r.out_green, r.out_blue} = best_rgb;
            r.depth_value = q16_depth(nn - idx, nn);
            if (refine && idx > 1 && idx < nn - 1 && sc_before != 0 && sc_after != 0) begin
                sm = sc_before;
                s0 = best_sc;
                sp = sc_after;
                dd = sm - 2 * s0 + sp;
                if (dd != 0) begin
                    num = 2 * dd * (nn - idx) - (sm - sp);
                    den = 2 * dd * nn;
                    if (den < 0) begin
                        num = -num;
                        den = -den;
                    end
                    r.depth_value = q16_depth(num, den);
                end
            end
        end else begin
            r.out_red = it.pixel_red;
            r.out_green = it.pixel_green;
            r.out_blue = it.pixel_blue;
            r.depth_value = 17'd0;
        end
        pixel_results.insert(pixel_results.size(), r);
        img_ctr = 0;
        best_sc = 0;
        best_idx = 0;
        best_rgb = 0;
        prev_sc = 0;
        sc_before = 0;
        sc_after = 0;
    endtask

    assign o_pending = pixel_results.size();

    // Sample every channel at the clock edge.
    always @(posedge i_clk) begin
        t_out_item exp_r;
        if (!i_rst_n) begin
            thr = 0;
            cnt_reg = 7'd16;
            refine = 1'b1;
            img_ctr = 0;
            best_sc = 0;
            best_idx = 0;
            best_rgb = 0;
            prev_sc = 0;
            sc_before = 0;
            sc_after = 0;
            pixel_results.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_THRESHOLD: thr = i_cfg_data;
                    REG_IMAGE_COUNT: cnt_reg = i_cfg_data[6:0];
                    REG_REFINE: refine = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (pixel_results.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("Unexpected result transaction %p", i_out_data);
                end else begin
                    exp_r = pixel_results.pop_front();
                    if (exp_r !== i_out_data) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("Mismatch: expected %p, actual %p", exp_r, i_out_data);
                    end
                end
            end
            if (i_in_valid && i_in_ready) take_item(i_in_data);
        end
    end
endmodule

[verif/focus_stack_pixel_select_tb.sv]
// Testbench top for the focus stack pixel select block: clock, reset,
// stimulus and verdict. Depends on fsps_pkg and the checker module.
`timescale 1ns / 100ps

module focus_stack_pixel_select_tb;
    import fsps_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    t_in_item in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    t_out_item out_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [23:0] cfg_data = '0;
    int fail_count, pending;
    int idle_cycles = 0;
    bit no_gaps = 1'b0;
    bit rx_holdoff = 1'b0;
    int cur_n = 16;

    always #6 i_clk = ~i_clk;

    focus_stack_pixel_select dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_data(out_data),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    focus_stack_pixel_select_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_data(out_data),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Watchdog on cycles without any transaction.
    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver: random stall bursts, or a long hold-off on request.
    initial begin
        int k;
        forever begin
            @(posedge i_clk);
            if (rx_holdoff) begin
                out_ready <= 1'b0;
                for (k = 0; k < 300; k++) @(posedge i_clk);
                rx_holdoff = 1'b0;
                out_ready <= 1'b1;
            end else if (!no_gaps && $urandom_range(0, 5) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
                out_ready <= 1'b1;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Offer one input transaction, with an optional random gap first.
    task automatic send_item(logic [23:0] sc, logic [23:0] rgb);
        if (!no_gaps && $urandom_range(0, 7) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data <= {sc, rgb};
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
    endtask

    // Wait for all results, then let the divider drain.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // Offer one register write; the caller drops valid after its last write.
    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [23:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
    endtask

    task automatic set_config(logic [23:0] thr, logic [6:0] n, logic ref_on);
        drain();
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_IMAGE_COUNT, {17'd0, n});
        write_reg(REG_REFINE, {23'd0, ref_on});
        cfg_valid <= 1'b0;
        cur_n = (n == 0) ? 1 : ((n > 64) ? 64 : n);
    endtask

    // One pixel: a peaked profile with random content, or pure noise.
    task automatic send_pixel(int mode);
        int i, peak;
        logic [23:0] sc;
        peak = $urandom_range(0, cur_n - 1);
        for (i = 0; i < cur_n; i++) begin
            case (mode)
                0: sc = 24'($urandom());
                1: sc = (i == peak) ? 24'(24'hFFFFFF - $urandom_range(0, 3)) :
                        24'(($urandom() & 24'hFFFF) + 1);
                2: sc = 24'(1000000 - 3000 * (i - peak) * (i - peak) + $urandom_range(0, 2000));
                default: sc = 24'($urandom_range(0, 3));
            endcase
            send_item(sc, 24'($urandom()));
        end
    endtask

    initial begin
        int p, total;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: flat scores, extremes, peak at edges and near-edge.
        set_config(24'd0, 7'd4, 1'b1);
        send_item(24'd0, 24'h000000); send_item(24'd0, 24'hFFFFFF);
        send_item(24'd0, 24'h123456); send_item(24'd0, 24'hABCDEF);
        send_item(24'd5, 24'h010203); send_item(24'd9, 24'hFFFFFF);
        send_item(24'hFFFFFF, 24'h804020); send_item(24'd9, 24'h000000);
        send_item(24'd10, 24'h112233); send_item(24'd20, 24'h445566);
        send_item(24'd20, 24'h778899); send_item(24'd1, 24'hAABBCC);
        set_config(24'hFFFFFF, 7'd1, 1'b0);
        send_item(24'hFFFFFF, 24'h0F0F0F); send_item(24'd0, 24'hF0F0F0);
        set_config(24'd0, 7'd0, 1'b1);
        send_item(24'd3, 24'h010101);
        set_config(24'd0, 7'd5, 1'b1);
        // Tied peak: the earlier of two equal scores stays selected.
        send_item(24'd1, 24'h0); send_item(24'd2, 24'h0); send_item(24'd9, 24'h111111);
        send_item(24'd9, 24'h0); send_item(24'd0, 24'h0);
        set_config(24'd0, 7'd127, 1'b1);
        send_pixel(1);

        // Random phases over several settings.
        total = 0;
        for (p = 0; p < 14 && total < 1250; p++) begin
            case (p % 7)
                0: set_config(24'd0, 7'd8, 1'b1);
                1: set_config(24'($urandom_range(0, 1000000)), 7'($urandom_range(3, 12)), 1'b1);
                2: set_config(24'd0, 7'd2, 1'b1);
                3: set_config(24'($urandom()), 7'($urandom_range(1, 6)), 1'b0);
                4: set_config(24'd0, 7'($urandom_range(4, 10)), 1'b1);
                5: set_config(24'd500000, 7'd3, 1'b1);
                default: set_config(24'd0, 7'd16, 1'($urandom_range(0, 1)));
            endcase
            if (p == 9) no_gaps = 1'b1;
            if (p == 3) rx_holdoff = 1'b1;
            while (total < (p + 1) * 90) begin
                send_pixel($urandom_range(0, 9) < 7 ? $urandom_range(1, 2) :
                           $urandom_range(0, 3) == 0 ? 3 : 0);
                total += cur_n;
            end
            // Sender pause until every result is in.
            if (p == 5) drain();
        end
        set_config(24'd0, 7'd64, 1'b1);
        send_pixel(2);
        drain();

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
